FILE: src/sal_pkg.sv
`default_nettype none

package sal_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = ((CNT_W > 8) ? CNT_W : 8) + 2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_APPEND = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_INFEAS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INSERT,
    S_DELETE,
    S_ROTATE,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_PLACE,
    CM_SHIFT_UP,
    CM_SHIFT_DOWN,
    CM_ROTATE
  } cell_mode_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
    logic        [7:0]  position;
    logic        [7:0]  count;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] read_value;
    logic        [7:0]  list_length;
  } out_item_t;

  typedef struct packed {
    cell_mode_t         mode;
    logic [IDX_W-1:0]   sel;
    logic signed [31:0] value;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: src/sorted_array_list_engine.sv
`default_nettype none

// Bounded list of up to CAPACITY signed 32-bit words held in a row of cells,
// one word per cell. Each input transaction carries one operation: sorted
// insert (entries greater than the value move up one place), append, range
// delete (count entries from 1-based position; the gap closes), or read of
// one entry. Every transaction yields exactly one result transaction with a
// status (ok, infeasible arguments, list full), the read value (zero unless
// a read succeeds) and the list length afterwards. One transaction is worked
// on at a time; a finished result waits in an output register so the next
// transaction is taken while it is unread. A sorted insert walks the hole
// down one cell per cycle, one step per entry moved; a range delete makes
// one shift pass of the cell row per removed entry; a read turns the row
// once as a ring and catches the entry as it passes cell zero. Cell
// contents are not cleared at reset; only the length is.
module sorted_array_list_engine (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sal_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sal_pkg::out_item_t      out_data
);

  localparam int CAP   = sal_pkg::CAPACITY;
  localparam int IDX_W = sal_pkg::IDX_W;

  sal_pkg::cell_ctl_t ctl;
  logic signed [31:0] entry [CAP];
  logic [CAP-1:0]     gt;

  // sequencer: owns the length, the handshakes and the cell commands
  sal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .gt_i      (gt),
    .head_i    (entry[0]),
    .ctl       (ctl)
  );

  // row of cells; the top cell wraps to cell zero so the row can turn as a ring
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    sal_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(i)),
      .ctl      (ctl),
      .below_i  (entry[(i == 0) ? 0 : i - 1]),
      .above_i  (entry[(i == CAP - 1) ? 0 : i + 1]),
      .entry_o  (entry[i]),
      .gt_o     (gt[i])
    );
  end

endmodule

`default_nettype wire

FILE: src/sal_cell.sv
`default_nettype none

module sal_cell (
  input  wire logic                      clk,
  input  wire logic [sal_pkg::IDX_W-1:0] cell_idx,
  input  wire sal_pkg::cell_ctl_t        ctl,
  input  wire logic signed [31:0]        below_i,
  input  wire logic signed [31:0]        above_i,
  output logic signed [31:0]             entry_o,
  output logic                           gt_o
);

  logic signed [31:0] entry_r;
  logic signed [31:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctl.mode)
      sal_pkg::CM_HOLD: entry_nxt = entry_r;
      sal_pkg::CM_PLACE: begin
        if (cell_idx == ctl.sel) entry_nxt = ctl.value;
      end
      sal_pkg::CM_SHIFT_UP: begin
        if (cell_idx == ctl.sel) entry_nxt = below_i;
      end
      sal_pkg::CM_SHIFT_DOWN: begin
        if (cell_idx >= ctl.sel) entry_nxt = above_i;
      end
      sal_pkg::CM_ROTATE: entry_nxt = above_i;
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // new value sorts strictly below this entry
  assign gt_o    = (ctl.value < entry_r);
  assign entry_o = entry_r;

endmodule

`default_nettype wire

FILE: src/sal_ctrl.sv
`default_nettype none

module sal_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire sal_pkg::in_item_t            in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output sal_pkg::out_item_t                out_data,
  input  wire logic [sal_pkg::CAPACITY-1:0] gt_i,
  input  wire logic signed [31:0]           head_i,
  output sal_pkg::cell_ctl_t                ctl
);

  localparam int IDX_W = sal_pkg::IDX_W;
  localparam int CNT_W = sal_pkg::CNT_W;
  localparam int SUM_W = sal_pkg::SUM_W;

  sal_pkg::state_t    state_r, state_nxt;
  sal_pkg::in_item_t  item_r, item_nxt;
  sal_pkg::out_item_t res_r, res_nxt;
  sal_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [IDX_W-1:0]   s_r, s_nxt;
  logic               idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sal_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      k_r         <= '0;
      s_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      s_r         <= s_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    s_nxt         = s_r;
    idle          = 1'b0;
    ctl.mode      = sal_pkg::CM_HOLD;
    ctl.sel       = '0;
    ctl.value     = item_r.value;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      sal_pkg::S_IDLE: begin
        idle = 1'b1;
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = sal_pkg::S_DISPATCH;
        end
      end
      sal_pkg::S_DISPATCH: begin
        res_nxt.status      = sal_pkg::ST_OK;
        res_nxt.read_value  = '0;
        res_nxt.list_length = 8'(n_r);
        state_nxt           = sal_pkg::S_DONE;
        unique case (item_r.op)
          sal_pkg::OP_INSERT: begin
            if (n_r == CNT_W'(sal_pkg::CAPACITY)) begin
              res_nxt.status = sal_pkg::ST_FULL;
            end else begin
              s_nxt     = IDX_W'(n_r);
              state_nxt = sal_pkg::S_INSERT;
            end
          end
          sal_pkg::OP_APPEND: begin
            if (n_r == CNT_W'(sal_pkg::CAPACITY)) begin
              res_nxt.status = sal_pkg::ST_FULL;
            end else begin
              ctl.mode            = sal_pkg::CM_PLACE;
              ctl.sel             = IDX_W'(n_r);
              n_nxt               = n_r + 1'b1;
              res_nxt.list_length = 8'(n_r + 1'b1);
            end
          end
          sal_pkg::OP_DELETE: begin
            if (item_r.position == 8'd0 ||
                (SUM_W'(item_r.position) + SUM_W'(item_r.count) >
                 SUM_W'(n_r) + SUM_W'(1))) begin
              res_nxt.status = sal_pkg::ST_INFEAS;
            end else if (item_r.count != 8'd0) begin
              k_nxt     = CNT_W'(item_r.count);
              s_nxt     = IDX_W'(item_r.position - 8'd1);
              state_nxt = sal_pkg::S_DELETE;
            end
          end
          sal_pkg::OP_READ: begin
            if (item_r.position == 8'd0 ||
                SUM_W'(item_r.position) > SUM_W'(n_r)) begin
              res_nxt.status = sal_pkg::ST_INFEAS;
            end else begin
              k_nxt     = '0;
              state_nxt = sal_pkg::S_ROTATE;
            end
          end
          default: res_nxt.status = sal_pkg::ST_INFEAS;
        endcase
      end
      sal_pkg::S_INSERT: begin
        // walk the hole down while the entry below sorts above the new value
        ctl.sel = s_r;
        if (s_r != '0 && gt_i[s_r - 1'b1]) begin
          ctl.mode = sal_pkg::CM_SHIFT_UP;
          s_nxt    = s_r - 1'b1;
        end else begin
          ctl.mode            = sal_pkg::CM_PLACE;
          n_nxt               = n_r + 1'b1;
          res_nxt.list_length = 8'(n_r + 1'b1);
          state_nxt           = sal_pkg::S_DONE;
        end
      end
      sal_pkg::S_DELETE: begin
        // one pass closes the gap by one place
        ctl.mode = sal_pkg::CM_SHIFT_DOWN;
        ctl.sel  = s_r;
        n_nxt    = n_r - 1'b1;
        k_nxt    = k_r - 1'b1;
        if (k_r == CNT_W'(1)) begin
          res_nxt.list_length = 8'(n_r - 1'b1);
          state_nxt           = sal_pkg::S_DONE;
        end
      end
      sal_pkg::S_ROTATE: begin
        // full turn of the ring; catch the wanted entry as it passes cell zero
        ctl.mode = sal_pkg::CM_ROTATE;
        if (SUM_W'(k_r) + SUM_W'(1) == SUM_W'(item_r.position)) begin
          res_nxt.read_value = head_i;
        end
        k_nxt = k_r + 1'b1;
        if (k_r == CNT_W'(sal_pkg::CAPACITY - 1)) state_nxt = sal_pkg::S_DONE;
      end
      sal_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = sal_pkg::S_IDLE;
        end
      end
      default: state_nxt = sal_pkg::S_IDLE;
    endcase
  end

  assign in_ready  = idle && rst_n;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

FILE: src/sal_checker.sv
`default_nettype none

module sal_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire sal_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire sal_pkg::out_item_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one transaction at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != sal_pkg::ST_OK |-> out_data.read_value == 32'sd0)
    else $error("read value not zero on failure");

  a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == sal_pkg::ST_FULL |->
      out_data.list_length == 8'(sal_pkg::CAPACITY))
    else $error("full reported below capacity");

endmodule

bind sorted_array_list_engine sal_checker u_sal_checker (.*);

`default_nettype wire
